/* hdl/scf_pkg.sv */
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the strip cluster finder
// Field widths, configuration register indexes, result and queue entry
// formats, and the good-hit rule.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int unsigned LAYERS     = 4;
  localparam int unsigned LAYER_W    = 2;
  localparam int unsigned STRIP_W    = 10;
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CHARGE_W   = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX  = '1;
  localparam logic [COUNT_W-1:0]  GOOD_STRIPS = COUNT_W'(2);
  localparam logic [COUNT_W-1:0]  ONE_STRIP   = COUNT_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIP  = 3'd4;

  typedef struct packed {
    logic [LAYER_W-1:0]  cluster_layer;
    logic [STRIP_W-1:0]  first_strip;
    logic [COUNT_W-1:0]  strip_count;
    logic [CHARGE_W-1:0] charge_sum;
    logic                good_hit;
    logic                last_of_run;
  } result_t;

  // one queue entry holds every result of one input beat
  typedef struct packed {
    logic    vld_b;
    logic    vld_a;
    result_t res_a;
    result_t res_b;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic good_hit(input logic [COUNT_W-1:0]  cnt,
                                    input logic [CHARGE_W-1:0] chg,
                                    input logic [CHARGE_W-1:0] mip);
    return (cnt <= GOOD_STRIPS) && (chg <= mip);
  endfunction

endpackage

/* hdl/scf_in_if.sv */
// ----------------------------------------------------------------------------
// scf_in_if: strip hit channel
// One beat carries one hit strip.
// ----------------------------------------------------------------------------
interface scf_in_if import scf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LAYER_W-1:0]  layer_index;
  logic [STRIP_W-1:0]  strip_number;
  logic [ADC_W-1:0]    adc_value;
  logic                last_in_layer;

  modport source (output valid, layer_index, strip_number, adc_value, last_in_layer,
                  input ready);
  modport sink   (input valid, layer_index, strip_number, adc_value, last_in_layer,
                  output ready);
endinterface

/* hdl/scf_out_if.sv */
// ----------------------------------------------------------------------------
// scf_out_if: cluster result channel
// One beat carries one finished cluster.
// ----------------------------------------------------------------------------
interface scf_out_if import scf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LAYER_W-1:0]  cluster_layer;
  logic [STRIP_W-1:0]  first_strip;
  logic [COUNT_W-1:0]  strip_count;
  logic [CHARGE_W-1:0] charge_sum;
  logic                good_hit;
  logic                last_of_run;

  modport source (output valid, cluster_layer, first_strip, strip_count, charge_sum,
                  good_hit, last_of_run, input ready);
  modport sink   (input valid, cluster_layer, first_strip, strip_count, charge_sum,
                  good_hit, last_of_run, output ready);
endinterface

/* hdl/scf_cfg_if.sv */
// ----------------------------------------------------------------------------
// scf_cfg_if: configuration write channel
// One beat writes one register.
// ----------------------------------------------------------------------------
interface scf_cfg_if import scf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/scf_front.sv */
// ----------------------------------------------------------------------------
// scf_front: strip classifier and cluster builder
// Holds the configuration registers and the open cluster, classifies each
// strip beat and pushes the clusters it closes into the result queue.
// ----------------------------------------------------------------------------
module scf_front import scf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_in_if.sink     in_i,
  scf_cfg_if.sink    cfg_i,
  input  qstat_t     qstat_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [ADC_W-1:0]    thr_q [LAYERS];
  logic [CHARGE_W-1:0] mip_q;

  logic                open_q, open_d;
  logic [LAYER_W-1:0]  layer_q, layer_d;
  logic [STRIP_W-1:0]  start_q, start_d;
  logic [STRIP_W-1:0]  prev_q, prev_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [CHARGE_W-1:0] chg_q, chg_d;

  logic                accept, layer_ok, above, adjacent, extend, emit_a, emit_b, open_mid;
  logic [COUNT_W-1:0]  cnt_inc;
  logic [CHARGE_W:0]   chg_sum;
  logic [CHARGE_W-1:0] chg_sat;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !qstat_i.full;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAYERS; i++) begin
        thr_q[i] <= '0;
      end
      mip_q <= CHARGE_MAX;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_THR0: thr_q[0] <= cfg_i.data[ADC_W-1:0];
        REG_THR1: thr_q[1] <= cfg_i.data[ADC_W-1:0];
        REG_THR2: thr_q[2] <= cfg_i.data[ADC_W-1:0];
        REG_THR3: thr_q[3] <= cfg_i.data[ADC_W-1:0];
        REG_MIP:  mip_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    layer_ok = {1'b0, in_i.layer_index} < (LAYER_W+1)'(LAYERS);
    above    = in_i.adc_value >= thr_q[in_i.layer_index];
    // no wrap: the carry bit keeps the top strip from matching strip zero
    adjacent = ({1'b0, prev_q} + (STRIP_W+1)'(1)) == {1'b0, in_i.strip_number};
    extend   = open_q && above && (layer_q == in_i.layer_index) && adjacent;
    emit_a   = open_q && !extend;
    open_mid = extend || above;
    emit_b   = in_i.last_in_layer && open_mid;

    cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + ONE_STRIP;
    chg_sum  = {1'b0, chg_q} + (CHARGE_W+1)'(in_i.adc_value);
    chg_sat  = chg_sum[CHARGE_W] ? CHARGE_MAX : chg_sum[CHARGE_W-1:0];

    layer_d = layer_q;
    start_d = start_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    chg_d   = chg_q;
    if (extend) begin
      prev_d = in_i.strip_number;
      cnt_d  = cnt_inc;
      chg_d  = chg_sat;
    end else if (above) begin
      layer_d = in_i.layer_index;
      start_d = in_i.strip_number;
      prev_d  = in_i.strip_number;
      cnt_d   = ONE_STRIP;
      chg_d   = CHARGE_W'(in_i.adc_value);
    end
    open_d = open_mid && !in_i.last_in_layer;
  end

  always_comb begin
    job_o.vld_a               = emit_a;
    job_o.vld_b               = emit_b;
    job_o.res_a.cluster_layer = layer_q;
    job_o.res_a.first_strip   = start_q;
    job_o.res_a.strip_count   = cnt_q;
    job_o.res_a.charge_sum    = chg_q;
    job_o.res_a.good_hit      = good_hit(cnt_q, chg_q, mip_q);
    job_o.res_a.last_of_run   = !emit_b;
    job_o.res_b.cluster_layer = layer_d;
    job_o.res_b.first_strip   = start_d;
    job_o.res_b.strip_count   = cnt_d;
    job_o.res_b.charge_sum    = chg_d;
    job_o.res_b.good_hit      = good_hit(cnt_d, chg_d, mip_q);
    job_o.res_b.last_of_run   = 1'b1;
    push_o = accept && layer_ok && (emit_a || emit_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      layer_q <= '0;
      start_q <= '0;
      prev_q  <= '0;
      cnt_q   <= '0;
      chg_q   <= '0;
    end else if (accept && layer_ok) begin
      open_q  <= open_d;
      layer_q <= layer_d;
      start_q <= start_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      chg_q   <= chg_d;
    end
  end

endmodule

/* hdl/scf_queue.sv */
// ----------------------------------------------------------------------------
// scf_queue: result queue
// Short register FIFO between the cluster builder and the output sequencer.
// ----------------------------------------------------------------------------
module scf_queue import scf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  job_t   job_i,
  input  logic   pop_i,
  output job_t   head_o,
  output qstat_t qstat_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/scf_back.sv */
// ----------------------------------------------------------------------------
// scf_back: output sequencer
// Sends the one or two clusters of each queue entry as separate beats.
// ----------------------------------------------------------------------------
module scf_back import scf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  job_t   head_i,
  input  qstat_t qstat_i,
  output logic   pop_o,
  scf_out_if.source out_o
);

  logic    second_q, second_d;
  logic    sel_b, fire;
  result_t res;

  always_comb begin
    sel_b    = second_q || !head_i.vld_a;
    res      = sel_b ? head_i.res_b : head_i.res_a;
    fire     = out_o.valid && out_o.ready;
    second_d = second_q;
    pop_o    = 1'b0;
    if (fire) begin
      // hold the entry for its second cluster
      if (!sel_b && head_i.vld_b) begin
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  assign out_o.valid         = !qstat_i.empty;
  assign out_o.cluster_layer = res.cluster_layer;
  assign out_o.first_strip   = res.first_strip;
  assign out_o.strip_count   = res.strip_count;
  assign out_o.charge_sum    = res.charge_sum;
  assign out_o.good_hit      = res.good_hit;
  assign out_o.last_of_run   = res.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else begin
      second_q <= second_d;
    end
  end

endmodule

/* hdl/strip_cluster_finder.sv */
// A closed cluster is queued with the strip beat that closes it, then offered on out_o.
// Throughput: one strip beat per cycle while the queue is not full; a beat that closes two
//   clusters leaves as two output beats, and the four-entry result queue absorbs that.
// Input stalls only when the result queue is full.
// Reset: no open cluster, queue empty, thresholds 0, MIP limit at full scale.
// ----------------------------------------------------------------------------
// strip_cluster_finder: threshold clustering of silicon strip hits
// Builds clusters of adjacent above-threshold strips per layer and reports
// first strip, strip count, saturating charge and a good-hit flag.
// ----------------------------------------------------------------------------
module strip_cluster_finder import scf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scf_in_if.sink    in_i,
  scf_cfg_if.sink   cfg_i,
  scf_out_if.source out_o
);

  logic   push, pop;
  job_t   job, head;
  qstat_t qstat;

  scf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .qstat_i (qstat),
    .push_o  (push),
    .job_o   (job)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  scf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* hdl/scf_checker.sv */
// ----------------------------------------------------------------------------
// scf_checker: port-level checks of the strip cluster finder
// Watches the result channel for consistent cluster beats.
// ----------------------------------------------------------------------------
module scf_checker import scf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STRIP_W-1:0]  first_strip_i,
  input logic [COUNT_W-1:0]  strip_count_i,
  input logic [CHARGE_W-1:0] charge_sum_i,
  input logic                good_hit_i,
  input logic                last_of_run_i
);

  // stalled beat holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(first_strip_i) &&
      $stable(strip_count_i) && $stable(charge_sum_i) && $stable(good_hit_i) &&
      $stable(last_of_run_i))
    else $error("result beat changed while stalled");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> strip_count_i != '0)
    else $error("cluster with no strips");

  a_good_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && good_hit_i |-> strip_count_i <= GOOD_STRIPS)
    else $error("good hit on a wide cluster");

  // strips never wrap, so a cluster ends on or below the top strip
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, first_strip_i} + strip_count_i) <= (COUNT_W'(1) << STRIP_W))
    else $error("cluster runs past the last strip");

endmodule

bind strip_cluster_finder scf_checker u_scf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .first_strip_i (out_o.first_strip),
  .strip_count_i (out_o.strip_count),
  .charge_sum_i  (out_o.charge_sum),
  .good_hit_i    (out_o.good_hit),
  .last_of_run_i (out_o.last_of_run)
);
